/* hw/rtl/aluf_pkg.sv */
package aluf_pkg;

  // Operation codes carried on in_tuser.
  typedef enum logic [3:0] {
    K_PASS  = 4'd0,
    K_NAND  = 4'd1,
    K_SHR1  = 4'd2,
    K_ADD   = 4'd3,
    K_NOT   = 4'd4,
    K_AND   = 4'd5,
    K_OR    = 4'd6,
    K_XOR   = 4'd7,
    K_NEG   = 4'd8,
    K_SUB   = 4'd9,
    K_SHIFT = 4'd10,
    K_MUL   = 4'd11
  } kind_t;

  localparam int unsigned KIND_BITS  = 4;
  localparam int unsigned OPB_BITS   = 16;
  localparam int unsigned SHAMT_BITS = 6;
  localparam int unsigned RES_BITS   = 16;
  // Step counter: holds a right shift of 32 and any word width up to 63.
  localparam int unsigned CNT_BITS   = 6;

  typedef struct packed {
    logic n;
    logic v;
    logic c;
    logic z;
  } flags_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_POST
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic busy;
  } dp_sts_t;

endpackage

/* hw/rtl/aluf_ctrl.sv */
module aluf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  aluf_pkg::dp_sts_t sts,
  output aluf_pkg::dp_cmd_t cmd
);
  import aluf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_RUN;
      end
      S_RUN: begin
        if (!sts.busy) state_nxt = S_POST;
      end
      S_POST: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_RUN: begin
        cmd.step = sts.busy;
      end
      S_POST: begin
        cmd.publish = slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.publish) out_valid_nxt = 1'b1;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/aluf_dp.sv */
module aluf_dp #(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  aluf_pkg::dp_cmd_t                   cmd,
  output aluf_pkg::dp_sts_t                   sts,
  input  aluf_pkg::kind_t                     kind,
  input  logic signed [aluf_pkg::OPB_BITS-1:0]   operand_b,
  input  logic signed [aluf_pkg::SHAMT_BITS-1:0] shift_amount,
  output logic signed [aluf_pkg::RES_BITS-1:0]   acc_value,
  output aluf_pkg::flags_t                    flags
);
  import aluf_pkg::*;

  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  flags_t               flg_r, flg_nxt;
  kind_t                kind_r, kind_nxt;
  logic                 shl_r, shl_nxt;
  logic [WORD_BITS-1:0] mcand_r, mcand_nxt;
  logic [WORD_BITS-1:0] mplier_r, mplier_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic [RES_BITS-1:0]  res_acc_r;
  flags_t               res_flg_r;

  logic [WORD_BITS-1:0] b_w;
  logic [WORD_BITS-1:0] add_x, add_y;
  logic [WORD_BITS:0]   sum;
  flags_t               add_flg;

  // Operand sign-extended (or truncated) to the word width.
  assign b_w = WORD_BITS'(operand_b);

  // The main adder of the datapath, shared by add, negate, subtract,
  // doubling and the multiply steps.
  always_comb begin
    add_x = acc_r;
    add_y = b_w;
    if (cmd.load) begin
      unique case (kind)
        K_NEG:   begin
          add_x = ~acc_r;
          add_y = WORD_BITS'(1);
        end
        K_SUB:   begin
          add_x = ~b_w + WORD_BITS'(1);
          add_y = acc_r;
        end
        default: begin
          add_x = acc_r;
          add_y = b_w;
        end
      endcase
    end else if (kind_r == K_MUL) begin
      add_y = mcand_r;
    end else begin
      add_y = acc_r;
    end
  end

  assign sum       = {1'b0, add_x} + {1'b0, add_y};
  assign add_flg.z = (sum[WORD_BITS-1:0] == '0);
  assign add_flg.c = sum[WORD_BITS];
  assign add_flg.v = sum[WORD_BITS] ^ (add_x[WORD_BITS-1] ^ add_y[WORD_BITS-1] ^
                                       sum[WORD_BITS-1]);
  assign add_flg.n = sum[WORD_BITS-1];

  always_comb begin
    acc_nxt    = acc_r;
    flg_nxt    = flg_r;
    kind_nxt   = kind_r;
    shl_nxt    = shl_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    if (cmd.load) begin
      kind_nxt = kind;
      cnt_nxt  = '0;
      case (kind)
        K_PASS: begin
          acc_nxt = b_w;
          flg_nxt = '0;
        end
        K_NAND: begin
          acc_nxt = ~(acc_r & b_w);
          flg_nxt = '0;
        end
        K_SHR1: begin
          acc_nxt = acc_r >> 1;
          flg_nxt = '0;
        end
        K_NOT: begin
          acc_nxt = ~acc_r;
          flg_nxt = '0;
        end
        K_AND: begin
          acc_nxt = acc_r & b_w;
          flg_nxt = '0;
        end
        K_OR: begin
          acc_nxt = acc_r | b_w;
          flg_nxt = '0;
        end
        K_XOR: begin
          acc_nxt = acc_r ^ b_w;
          flg_nxt = '0;
        end
        K_ADD, K_NEG, K_SUB: begin
          acc_nxt = sum[WORD_BITS-1:0];
          flg_nxt = add_flg;
        end
        K_SHIFT: begin
          shl_nxt = !shift_amount[SHAMT_BITS-1];
          cnt_nxt = shift_amount[SHAMT_BITS-1] ? CNT_BITS'(-shift_amount)
                                               : CNT_BITS'(shift_amount);
        end
        K_MUL: begin
          acc_nxt    = '0;
          flg_nxt    = '0;
          mcand_nxt  = acc_r;
          mplier_nxt = b_w;
          cnt_nxt    = CNT_BITS'(WORD_BITS);
        end
        default: begin
          acc_nxt = acc_r;
        end
      endcase
    end else if (cmd.step) begin
      cnt_nxt = cnt_r - CNT_BITS'(1);
      if (kind_r == K_MUL) begin
        if (mplier_r[0]) acc_nxt = sum[WORD_BITS-1:0];
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
      end else if (shl_r) begin
        // Doubling through the adder gives the flags of each addition.
        acc_nxt = sum[WORD_BITS-1:0];
        flg_nxt = add_flg;
      end else begin
        acc_nxt   = acc_r >> 1;
        flg_nxt   = '0;
        flg_nxt.c = acc_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      flg_r  <= '0;
      cnt_r  <= '0;
      kind_r <= K_PASS;
    end else begin
      acc_r  <= acc_nxt;
      flg_r  <= flg_nxt;
      cnt_r  <= cnt_nxt;
      kind_r <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shl_r    <= shl_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    if (cmd.publish) begin
      res_acc_r <= RES_BITS'(signed'(acc_r));
      res_flg_r <= flg_r;
    end
  end

  assign sts.busy  = (cnt_r != '0);
  assign acc_value = res_acc_r;
  assign flags     = res_flg_r;

endmodule

/* hw/rtl/accumulator_alu_with_flags.sv */
// Accumulator ALU with zero, carry, overflow and negative flags. Each input
// transaction carries an operation code on in_tuser and an operand word and
// a signed shift amount on in_tdata; it updates the accumulator and flags
// and produces exactly one output transaction with the new accumulator
// (sign-extended or truncated to 16 bits) and the four flags. Items are
// processed one at a time through a shared adder and shift logic stepped
// by the controller: logic, add, negate and subtract complete on acceptance,
// a shift by n steps one bit per cycle, a multiply steps one multiplier
// bit per cycle, and every item passes through the run and post states
// before the next acceptance. A result held in the output register does
// not stop the next item from being accepted. Operation codes 12 to 15
// leave accumulator and flags as they are and report them.
module accumulator_alu_with_flags #(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] operand_b, [21:16] shift_amount, [23:22] zero
  input  logic [3:0]  in_tuser,   // [3:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [15:0] acc_value, [16] zero_flag, [17] carry_flag,
                                  // [18] overflow_flag, [19] negative_flag, [23:20] zero
);
  import aluf_pkg::*;

  dp_cmd_t                       cmd;
  dp_sts_t                       sts;
  logic signed [RES_BITS-1:0]    acc_value;
  flags_t                        flags;

  aluf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  aluf_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (kind_t'(in_tuser)),
    .operand_b    (signed'(in_tdata[15:0])),
    .shift_amount (signed'(in_tdata[21:16])),
    .acc_value    (acc_value),
    .flags        (flags)
  );

  assign out_tdata = {4'b0000, flags.n, flags.v, flags.c, flags.z, acc_value};

endmodule
